[hw/rtl/nvmrq_pkg.sv]
// Shared types, constants and register indexes for the NVMe read queue engine.
// No dependencies; imported by every module of the block.
package nvmrq_pkg;

	localparam int DEF_QUEUE_DEPTH   = 64;
	localparam int DEF_DOORBELL_BASE = 4096;

	localparam int MAX_XFER_BYTES  = 8192;
	localparam int PAGE_BYTES      = 4096;
	localparam int MIN_BLOCK_LOG2  = 9;
	localparam int TIMEOUT_DEFAULT = 5000000;

	localparam int IN_DATA_W  = 160;
	localparam int OUT_DATA_W = 296;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLED         = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE_LOG2 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NAMESPACE_ID    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DOORBELL_STRIDE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_QUEUE_ID        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_QUEUE_ENTRIES   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_POLLS   = 3'd6;

	localparam logic REQ_READ = 1'b0;
	localparam logic REQ_POLL = 1'b1;

	typedef enum logic [2:0] {
		RK_SUBMITTED   = 3'd0,
		RK_REJECTED    = 3'd1,
		RK_BUSY        = 3'd2,
		RK_PENDING     = 3'd3,
		RK_COMPLETED   = 3'd4,
		RK_TIMEOUT     = 3'd5,
		RK_NOTHING_OUT = 3'd6
	} result_kind_t;

	typedef struct packed {
		logic        enabled;
		logic [3:0]  block_size_log2;
		logic [31:0] namespace_id;
		logic [3:0]  doorbell_stride;
		logic [3:0]  queue_id;
		logic [6:0]  queue_entries;
		logic [22:0] timeout_polls;
	} cfg_t;

	typedef struct packed {
		logic        req_type;
		logic [63:0] start_lba;
		logic [15:0] block_count;
		logic [63:0] buffer_address;
		logic [15:0] completion_word;
	} item_t;

	typedef struct packed {
		result_kind_t result_kind;
		logic [15:0]  command_id;
		logic [5:0]   slot_index;
		logic [63:0]  prp_first;
		logic [63:0]  prp_second;
		logic [63:0]  lba_out;
		logic [3:0]   blocks_minus_one;
		logic [31:0]  ns_out;
		logic [21:0]  doorbell_offset;
		logic [5:0]   doorbell_value;
		logic [14:0]  status_code;
	} result_t;

endpackage

[hw/rtl/nvmrq_cfg_regs.sv]
// Configuration register file of the NVMe read queue engine.
// Depends on nvmrq_pkg for register indexes and the cfg_t bundle.
module nvmrq_cfg_regs import nvmrq_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled         <= 1'b0;
			cfg_q.block_size_log2 <= 4'(MIN_BLOCK_LOG2);
			cfg_q.namespace_id    <= 32'd1;
			cfg_q.doorbell_stride <= 4'd0;
			cfg_q.queue_id        <= 4'd1;
			cfg_q.queue_entries   <= 7'd64;
			cfg_q.timeout_polls   <= 23'(TIMEOUT_DEFAULT);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ENABLED:         cfg_q.enabled         <= cfg_data[0];
				REG_BLOCK_SIZE_LOG2: cfg_q.block_size_log2 <= cfg_data[3:0];
				REG_NAMESPACE_ID:    cfg_q.namespace_id    <= cfg_data;
				REG_DOORBELL_STRIDE: cfg_q.doorbell_stride <= cfg_data[3:0];
				REG_QUEUE_ID:        cfg_q.queue_id        <= cfg_data[3:0];
				REG_QUEUE_ENTRIES:   cfg_q.queue_entries   <= cfg_data[6:0];
				REG_TIMEOUT_POLLS:   cfg_q.timeout_polls   <= cfg_data[22:0];
				default: begin
				end
			endcase
		end
	end

endmodule

[hw/rtl/nvmrq_core.sv]
// Queue pair state and single-pass result logic: read checks, submission entry,
// completion phase match and poll timeout. Depends on nvmrq_pkg.
module nvmrq_core import nvmrq_pkg::*; #(
	parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH,
	parameter int DOORBELL_BASE = DEF_DOORBELL_BASE
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  item_t   item,
	input  logic    fire,
	output result_t res
);

	localparam int IW  = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int RSW = (IW + 1 > 7) ? IW + 1 : 7;

	logic [IW-1:0] tail_q;
	logic [IW-1:0] head_q;
	logic          phase_q;
	logic [15:0]   cmd_id_q;
	logic          outstanding_q;
	logic [22:0]   poll_count_q;

	logic [IW-1:0]  tail_d;
	logic [IW-1:0]  head_d;
	logic           phase_d;
	logic [15:0]    cmd_id_d;
	logic           outstanding_d;
	logic [22:0]    poll_count_d;

	logic [3:0]     bsl;
	logic [RSW-1:0] ring_size;
	logic [RSW-1:0] tail_inc;
	logic [RSW-1:0] head_inc;
	logic [IW-1:0]  tail_nx;
	logic [IW-1:0]  head_nx;
	logic           bad_read;
	logic           two_pages;
	logic [22:0]    poll_inc;
	logic [4:0]     sq_sel;
	logic [4:0]     cq_sel;
	logic [4:0]     shamt;
	logic [21:0]    sq_db;
	logic [21:0]    cq_db;

	always_comb begin
		bsl = (cfg.block_size_log2 < 4'(MIN_BLOCK_LOG2)) ? 4'(MIN_BLOCK_LOG2) :
			cfg.block_size_log2;
		bad_read  = !cfg.enabled || (item.block_count == 16'd0) ||
			(item.block_count > 16'(MAX_XFER_BYTES >> bsl));
		two_pages = {16'd0, item.block_count} > (32'(PAGE_BYTES) >> bsl);

		if (RSW'(cfg.queue_entries) < RSW'(2))
			ring_size = RSW'(2);
		else if (RSW'(cfg.queue_entries) > RSW'(QUEUE_DEPTH))
			ring_size = RSW'(QUEUE_DEPTH);
		else
			ring_size = RSW'(cfg.queue_entries);

		tail_inc = RSW'(tail_q) + RSW'(1);
		head_inc = RSW'(head_q) + RSW'(1);
		tail_nx  = (tail_inc >= ring_size) ? '0 : tail_inc[IW-1:0];
		head_nx  = (head_inc >= ring_size) ? '0 : head_inc[IW-1:0];

		sq_sel = {cfg.queue_id, 1'b0};
		cq_sel = {cfg.queue_id, 1'b1};
		shamt  = {1'b0, cfg.doorbell_stride} + 5'd2;
		sq_db  = 22'(23'(DOORBELL_BASE) + (23'(sq_sel) << shamt));
		cq_db  = 22'(23'(DOORBELL_BASE) + (23'(cq_sel) << shamt));

		poll_inc = poll_count_q + 23'd1;
	end

	always_comb begin
		res           = '0;
		res.result_kind = RK_SUBMITTED;
		tail_d        = tail_q;
		head_d        = head_q;
		phase_d       = phase_q;
		cmd_id_d      = cmd_id_q;
		outstanding_d = outstanding_q;
		poll_count_d  = poll_count_q;

		if (item.req_type == REQ_READ) begin
			if (bad_read) begin
				res.result_kind = RK_REJECTED;
			end else if (outstanding_q) begin
				res.result_kind = RK_BUSY;
			end else begin
				res.result_kind      = RK_SUBMITTED;
				res.command_id       = cmd_id_q;
				res.slot_index       = 6'(tail_q);
				res.prp_first        = item.buffer_address;
				res.prp_second       = two_pages ?
					item.buffer_address + 64'(PAGE_BYTES) : 64'd0;
				res.lba_out          = item.start_lba;
				res.blocks_minus_one = 4'(item.block_count - 16'd1);
				res.ns_out           = cfg.namespace_id;
				res.doorbell_offset  = sq_db;
				res.doorbell_value   = 6'(tail_nx);
				cmd_id_d      = cmd_id_q + 16'd1;
				tail_d        = tail_nx;
				outstanding_d = 1'b1;
				poll_count_d  = '0;
			end
		end else if (!outstanding_q) begin
			res.result_kind = RK_NOTHING_OUT;
		end else if (item.completion_word[0] == phase_q) begin
			res.result_kind     = RK_COMPLETED;
			res.command_id      = cmd_id_q - 16'd1;
			res.status_code     = item.completion_word[15:1];
			res.doorbell_offset = cq_db;
			res.doorbell_value  = 6'(head_nx);
			head_d        = head_nx;
			phase_d       = (head_nx == '0) ? !phase_q : phase_q;
			outstanding_d = 1'b0;
			poll_count_d  = '0;
		end else if (poll_inc >= cfg.timeout_polls) begin
			res.result_kind = RK_TIMEOUT;
			res.command_id  = cmd_id_q - 16'd1;
			outstanding_d   = 1'b0;
			poll_count_d    = '0;
		end else begin
			res.result_kind = RK_PENDING;
			poll_count_d    = poll_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_q        <= '0;
			head_q        <= '0;
			phase_q       <= 1'b1;
			cmd_id_q      <= '0;
			outstanding_q <= 1'b0;
			poll_count_q  <= '0;
		end else if (fire) begin
			tail_q        <= tail_d;
			head_q        <= head_d;
			phase_q       <= phase_d;
			cmd_id_q      <= cmd_id_d;
			outstanding_q <= outstanding_d;
			poll_count_q  <= poll_count_d;
		end
	end

endmodule

[hw/rtl/nvme_read_queue_engine.sv]
// NVMe read queue engine: input word register, queue pair core, result register.
// An accepted word waits in the input register until fire, then passes the core into the
// result register; m_tvalid rises in the cycle after fire. Throughput: one word per cycle
// while m_tready does not stall, set by the single pass through the core between the two
// registers; m_tready low holds both. Reset: arst_n clears pointers, command id, counters
// and the valid flags of both word registers, sets the phase to 1 and returns config to its defaults.
module nvme_read_queue_engine import nvmrq_pkg::*; #(
	parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH,
	parameter int DOORBELL_BASE = DEF_DOORBELL_BASE
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// start_lba[63:0], block_count[79:64], buffer_address[143:80],
	// completion_word[159:144]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// req_type[0]
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// command_id[15:0], slot_index[21:16], prp_first[85:22], prp_second[149:86],
	// lba_out[213:150], blocks_minus_one[217:214], ns_out[249:218],
	// doorbell_offset[271:250], doorbell_value[277:272], status_code[292:278]
	output logic [OUT_DATA_W-1:0] m_tdata,
	// result_kind[2:0]
	output logic [2:0]            m_tuser,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	result_t res_s2;
	logic    valid_s2;
	logic    fire;

	assign fire     = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || fire;

	nvmrq_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	nvmrq_core #(
		.QUEUE_DEPTH   (QUEUE_DEPTH),
		.DOORBELL_BASE (DOORBELL_BASE)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item_s1),
		.fire   (fire),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.req_type        <= s_tuser;
			item_s1.start_lba       <= s_tdata[63:0];
			item_s1.block_count     <= s_tdata[79:64];
			item_s1.buffer_address  <= s_tdata[143:80];
			item_s1.completion_word <= s_tdata[159:144];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.result_kind;
	assign m_tdata  = {
		3'd0,
		res_s2.status_code,
		res_s2.doorbell_value,
		res_s2.doorbell_offset,
		res_s2.ns_out,
		res_s2.blocks_minus_one,
		res_s2.lba_out,
		res_s2.prp_second,
		res_s2.prp_first,
		res_s2.slot_index,
		res_s2.command_id
	};

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for nvme_read_queue_engine: a shadow queue pair predicts each result word.
// Covers a directed table, a back-to-back read/poll run and random config phases with stalls.
// Depends on nvmrq_pkg and the engine RTL.
module tb;
	import nvmrq_pkg::*;

	localparam int IDLE_LIMIT    = 500;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_WORDS   = 130;
	localparam int SWEEP_CMDS    = 24;
	localparam int DIR_ROWS      = 33;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct {
		bit                   is_cfg;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [31:0]          reg_val;
		logic                 req;
		logic [63:0]          lba;
		logic [15:0]          count;
		logic [63:0]          addr;
		logic [15:0]          cword;
		bit                   known;
		result_kind_t         kind;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [2:0]            m_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	cfg_t        shadow_cfg;
	logic [5:0]  sq_tail;
	logic [5:0]  cq_head;
	logic        head_phase;
	logic [15:0] cid_next;
	logic        cmd_open;
	logic [22:0] miss_polls;

	result_t     due_results [$];
	result_t     exp_r;
	int          mismatches = 0;
	int          burst_left = 0;
	bit          no_gaps = 1'b0;
	int          idle_cycles = 0;
	int          rx_mode = 0;
	int          rx_left = 0;
	logic [7:0]  rx_tick = '0;

	dir_row_t directed_rows [DIR_ROWS] = '{
		'{0, REG_ENABLED, 0, REQ_POLL, 64'h0, 16'd0, 64'h0, 16'h0001, 1, RK_NOTHING_OUT},
		'{0, REG_ENABLED, 0, REQ_READ, 64'h0, 16'd1, 64'h1000, 16'h0, 1, RK_REJECTED},
		'{1, REG_ENABLED, 1, REQ_READ, 64'h0, 16'd0, 64'h0, 16'h0, 0, RK_SUBMITTED},
		'{0, REG_ENABLED, 0, REQ_READ, 64'h5, 16'd0, 64'h2000, 16'h0, 1, RK_REJECTED},
		'{0, REG_ENABLED, 0, REQ_READ, 64'h5, 16'd17, 64'h2000, 16'h0, 1, RK_REJECTED},
		'{0, REG_ENABLED, 0, REQ_READ, {64{1'b1}}, 16'd16, {64{1'b1}}, 16'hFFFF, 0,
			RK_SUBMITTED},
		'{0, REG_ENABLED, 0, REQ_READ, 64'h7, 16'd1, 64'h3000, 16'h0, 1, RK_BUSY},
		'{0, REG_ENABLED, 0, REQ_POLL, 64'h0, 16'd0, 64'h0, 16'hFFFE, 1, RK_PENDING},
		'{0, REG_ENABLED, 0, REQ_POLL, 64'h0, 16'd0, 64'h0, 16'hFFFF, 0, RK_SUBMITTED},
		'{0, REG_ENABLED, 0, REQ_READ, 64'h0, 16'd8, 64'h0, 16'h0, 0, RK_SUBMITTED},
		'{0, REG_ENABLED, 0, REQ_POLL, 64'h0, 16'd0, 64'h0, 16'h0001, 0, RK_SUBMITTED},
		'{1, REG_TIMEOUT_POLLS, 0, REQ_READ, 64'h0, 16'd0, 64'h0, 16'h0, 0, RK_SUBMITTED},
		'{0, REG_ENABLED, 0, REQ_READ, 64'h0F0F_0F0F_0F0F_0F0F, 16'd1,
			64'h0123_4567_89AB_CDEF, 16'h0, 0, RK_SUBMITTED},
		'{0, REG_ENABLED, 0, REQ_POLL, 64'h0, 16'd0, 64'h0, 16'h0000, 0, RK_SUBMITTED},
		'{1, REG_TIMEOUT_POLLS, 2, REQ_READ, 64'h0, 16'd0, 64'h0, 16'h0, 0, RK_SUBMITTED},
		'{0, REG_ENABLED, 0, REQ_READ, 64'h100, 16'd9, 64'hFFFF_F000, 16'h0, 0,
			RK_SUBMITTED},
		'{0, REG_ENABLED, 0, REQ_POLL, 64'h0, 16'd0, 64'h0, 16'h0000, 1, RK_PENDING},
		'{0, REG_ENABLED, 0, REQ_POLL, 64'h0, 16'd0, 64'h0, 16'h0000, 0, RK_SUBMITTED},
		'{1, REG_BLOCK_SIZE_LOG2, 15, REQ_READ, 64'h0, 16'd0, 64'h0, 16'h0, 0, RK_SUBMITTED},
		'{0, REG_ENABLED, 0, REQ_READ, 64'h1, 16'd1, 64'h4000, 16'h0, 1, RK_REJECTED},
		'{1, REG_BLOCK_SIZE_LOG2, 3, REQ_READ, 64'h0, 16'd0, 64'h0, 16'h0, 0, RK_SUBMITTED},
		'{0, REG_ENABLED, 0, REQ_READ, 64'h2, 16'd16, 64'h8000, 16'h0, 0, RK_SUBMITTED},
		'{0, REG_ENABLED, 0, REQ_POLL, 64'h0, 16'd0, 64'h0, 16'h0003, 0, RK_SUBMITTED},
		'{1, REG_BLOCK_SIZE_LOG2, 13, REQ_READ, 64'h0, 16'd0, 64'h0, 16'h0, 0, RK_SUBMITTED},
		'{0, REG_ENABLED, 0, REQ_READ, 64'h3, 16'd1, 64'hA000, 16'h0, 0, RK_SUBMITTED},
		'{0, REG_ENABLED, 0, REQ_POLL, 64'h0, 16'd0, 64'h0, 16'hFFFF, 0, RK_SUBMITTED},
		'{1, REG_UNUSED, 32'hFFFF_FFFF, REQ_READ, 64'h0, 16'd0, 64'h0, 16'h0, 0,
			RK_SUBMITTED},
		'{1, REG_QUEUE_ENTRIES, 2, REQ_READ, 64'h0, 16'd0, 64'h0, 16'h0, 0, RK_SUBMITTED},
		'{0, REG_ENABLED, 0, REQ_READ, 64'h4, 16'd1, 64'hB000, 16'h0, 0, RK_SUBMITTED},
		'{0, REG_ENABLED, 0, REQ_POLL, 64'h0, 16'd0, 64'h0, 16'h0001, 0, RK_SUBMITTED},
		'{0, REG_ENABLED, 0, REQ_READ, 64'h5, 16'd1, 64'hC000, 16'h0, 0, RK_SUBMITTED},
		'{0, REG_ENABLED, 0, REQ_POLL, 64'h0, 16'd0, 64'h0, 16'h0001, 1, RK_PENDING},
		'{0, REG_ENABLED, 0, REQ_POLL, 64'h0, 16'd0, 64'h0, 16'h0000, 0, RK_SUBMITTED}
	};

	nvme_read_queue_engine uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int max_read_blocks();
		int bsl;
		bsl = shadow_cfg.block_size_log2;
		if (bsl < MIN_BLOCK_LOG2) bsl = MIN_BLOCK_LOG2;
		return MAX_XFER_BYTES >> bsl;
	endfunction

	function automatic logic [5:0] ring_advance(input logic [5:0] idx);
		int len;
		int n;
		len = shadow_cfg.queue_entries;
		if (len < 2) len = 2;
		if (len > DEF_QUEUE_DEPTH) len = DEF_QUEUE_DEPTH;
		n = int'(idx) + 1;
		return (n >= len) ? 6'd0 : 6'(n);
	endfunction

	function automatic logic [21:0] doorbell_at(input int which);
		int spacing;
		spacing = 4 << int'(shadow_cfg.doorbell_stride);
		return 22'(DEF_DOORBELL_BASE + (2 * int'(shadow_cfg.queue_id) + which) * spacing);
	endfunction

	function automatic result_t queue_pair_predict(input item_t it);
		result_t r;
		int bsl;
		int xfer_bytes;
		r = '0;
		if (it.req_type == REQ_READ) begin
			bsl = shadow_cfg.block_size_log2;
			if (bsl < MIN_BLOCK_LOG2) bsl = MIN_BLOCK_LOG2;
			if (!shadow_cfg.enabled || it.block_count == 16'd0
					|| int'(it.block_count) > max_read_blocks()) begin
				r.result_kind = RK_REJECTED;
			end else if (cmd_open) begin
				r.result_kind = RK_BUSY;
			end else begin
				xfer_bytes = int'(it.block_count) << bsl;
				r.result_kind = RK_SUBMITTED;
				r.command_id = cid_next;
				r.slot_index = sq_tail;
				r.prp_first = it.buffer_address;
				r.prp_second = (xfer_bytes > PAGE_BYTES) ? it.buffer_address + 64'(PAGE_BYTES) : '0;
				r.lba_out = it.start_lba;
				r.blocks_minus_one = 4'(it.block_count - 16'd1);
				r.ns_out = shadow_cfg.namespace_id;
				cid_next = cid_next + 16'd1;
				sq_tail = ring_advance(sq_tail);
				r.doorbell_offset = doorbell_at(0);
				r.doorbell_value = sq_tail;
				cmd_open = 1'b1;
				miss_polls = '0;
			end
		end else if (!cmd_open) begin
			r.result_kind = RK_NOTHING_OUT;
		end else if (it.completion_word[0] == head_phase) begin
			r.result_kind = RK_COMPLETED;
			r.command_id = cid_next - 16'd1;
			r.status_code = it.completion_word[15:1];
			cq_head = ring_advance(cq_head);
			if (cq_head == 6'd0) head_phase = ~head_phase;
			r.doorbell_offset = doorbell_at(1);
			r.doorbell_value = cq_head;
			cmd_open = 1'b0;
			miss_polls = '0;
		end else begin
			miss_polls = miss_polls + 23'd1;
			if (miss_polls >= shadow_cfg.timeout_polls) begin
				r.result_kind = RK_TIMEOUT;
				r.command_id = cid_next - 16'd1;
				cmd_open = 1'b0;
				miss_polls = '0;
			end else begin
				r.result_kind = RK_PENDING;
			end
		end
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] got_v);
		if (exp_v !== got_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, got_v);
			mismatches++;
		end
	endfunction

	function automatic logic [31:0] with_junk(input logic [31:0] v, input int width,
			input bit junk);
		logic [31:0] keep;
		keep = (width >= 32) ? '1 : ((32'd1 << width) - 32'd1);
		return junk ? (($urandom & ~keep) | (v & keep)) : v;
	endfunction

	task automatic send_word(input item_t it, input bit known, input result_kind_t kind);
		result_t r;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			if (!no_gaps && $urandom_range(0, 4) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {it.completion_word, it.buffer_address, it.block_count, it.start_lba};
		s_tuser <= it.req_type;
		do @(posedge clk); while (!s_tready);
		r = queue_pair_predict(it);
		if (known) begin
			r = '0;
			r.result_kind = kind;
		end
		due_results.push_back(r);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_ENABLED:         shadow_cfg.enabled = val[0];
			REG_BLOCK_SIZE_LOG2: shadow_cfg.block_size_log2 = val[3:0];
			REG_NAMESPACE_ID:    shadow_cfg.namespace_id = val;
			REG_DOORBELL_STRIDE: shadow_cfg.doorbell_stride = val[3:0];
			REG_QUEUE_ID:        shadow_cfg.queue_id = val[3:0];
			REG_QUEUE_ENTRIES:   shadow_cfg.queue_entries = val[6:0];
			REG_TIMEOUT_POLLS:   shadow_cfg.timeout_polls = val[22:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic program_regs(input cfg_t c, input bit junk);
		write_reg(REG_ENABLED, with_junk(32'(c.enabled), 1, junk));
		write_reg(REG_BLOCK_SIZE_LOG2, with_junk(32'(c.block_size_log2), 4, junk));
		write_reg(REG_NAMESPACE_ID, c.namespace_id);
		write_reg(REG_DOORBELL_STRIDE, with_junk(32'(c.doorbell_stride), 4, junk));
		write_reg(REG_QUEUE_ID, with_junk(32'(c.queue_id), 4, junk));
		write_reg(REG_QUEUE_ENTRIES, with_junk(32'(c.queue_entries), 7, junk));
		write_reg(REG_TIMEOUT_POLLS, with_junk(32'(c.timeout_polls), 23, junk));
	endtask

	task automatic random_item(output item_t it);
		int roll;
		int top;
		it.req_type = REQ_POLL;
		it.start_lba = {$urandom, $urandom};
		it.block_count = 16'($urandom);
		it.buffer_address = {$urandom, $urandom};
		it.completion_word = 16'($urandom);
		roll = $urandom_range(0, 99);
		top = max_read_blocks();
		if (!cmd_open) begin
			if (roll < 85) begin
				it.req_type = REQ_READ;
				if (roll < 75 && top > 0) it.block_count = 16'($urandom_range(1, top));
				else if (roll < 80) it.block_count = 16'(top + 1);
			end
		end else if (roll < 8) begin
			it.req_type = REQ_READ;
			if (roll < 5 && top > 0) it.block_count = 16'($urandom_range(1, top));
		end else begin
			it.completion_word[0] = ($urandom_range(0, 99) < 45) ? head_phase : ~head_phase;
			if ($urandom_range(0, 1) == 0) it.completion_word[15:1] = '0;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (due_results.size() == 0) begin
				$error("unexpected result word, kind %0d", m_tuser);
				mismatches++;
			end else begin
				exp_r = due_results.pop_front();
				check_field("result_kind", 64'(exp_r.result_kind), 64'(m_tuser));
				check_field("command_id", 64'(exp_r.command_id), 64'(m_tdata[15:0]));
				check_field("slot_index", 64'(exp_r.slot_index), 64'(m_tdata[21:16]));
				check_field("prp_first", exp_r.prp_first, m_tdata[85:22]);
				check_field("prp_second", exp_r.prp_second, m_tdata[149:86]);
				check_field("lba_out", exp_r.lba_out, m_tdata[213:150]);
				check_field("blocks_minus_one", 64'(exp_r.blocks_minus_one),
					64'(m_tdata[217:214]));
				check_field("ns_out", 64'(exp_r.ns_out), 64'(m_tdata[249:218]));
				check_field("doorbell_offset", 64'(exp_r.doorbell_offset),
					64'(m_tdata[271:250]));
				check_field("doorbell_value", 64'(exp_r.doorbell_value),
					64'(m_tdata[277:272]));
				check_field("status_code", 64'(exp_r.status_code), 64'(m_tdata[292:278]));
				check_field("tdata_pad", 64'd0, 64'(m_tdata[OUT_DATA_W-1:293]));
			end
		end
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(20, 300);
		end
		rx_left--;
		rx_tick = rx_tick + 8'd1;
		case (rx_mode)
			0:       m_tready <= 1'b1;
			1:       m_tready <= 1'($urandom_range(0, 1));
			2:       m_tready <= (rx_tick[2:0] >= 3'd3);
			default: m_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		item_t it;
		cfg_t  c;
		int    n;
		int    ph;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		shadow_cfg = '{enabled: 1'b0, block_size_log2: 4'd9, namespace_id: 32'd1,
			doorbell_stride: 4'd0, queue_id: 4'd1, queue_entries: 7'(DEF_QUEUE_DEPTH),
			timeout_polls: 23'(TIMEOUT_DEFAULT)};
		sq_tail = '0;
		cq_head = '0;
		head_phase = 1'b1;
		cid_next = '0;
		cmd_open = 1'b0;
		miss_polls = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg) begin
				wait_drained();
				write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
			end else begin
				it.req_type = directed_rows[i].req;
				it.start_lba = directed_rows[i].lba;
				it.block_count = directed_rows[i].count;
				it.buffer_address = directed_rows[i].addr;
				it.completion_word = directed_rows[i].cword;
				send_word(it, directed_rows[i].known, directed_rows[i].kind);
			end
		end

		// run back-to-back read/poll pairs on a three-entry ring
		wait_drained();
		no_gaps = 1'b1;
		c.enabled = 1'b1;
		c.block_size_log2 = 4'd9;
		c.namespace_id = $urandom;
		c.doorbell_stride = 4'($urandom_range(0, 15));
		c.queue_id = 4'($urandom_range(0, 15));
		c.queue_entries = 7'd3;
		c.timeout_polls = 23'd1;
		program_regs(c, 1'b0);
		for (n = 0; n < SWEEP_CMDS; n++) begin
			it.req_type = REQ_READ;
			it.start_lba = {$urandom, $urandom};
			it.block_count = 16'($urandom_range(1, 16));
			it.buffer_address = {$urandom, $urandom};
			it.completion_word = 16'($urandom);
			send_word(it, 1'b0, RK_SUBMITTED);
			it.req_type = REQ_POLL;
			it.completion_word = 16'($urandom);
			send_word(it, 1'b0, RK_SUBMITTED);
		end
		wait_drained();
		no_gaps = 1'b0;

		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: c = '{enabled: 1'b1, block_size_log2: 4'd9, namespace_id: 32'd0,
					doorbell_stride: 4'd0, queue_id: 4'd0, queue_entries: 7'd2,
					timeout_polls: 23'd1};
				1: c = '{enabled: 1'b1, block_size_log2: 4'd13, namespace_id: 32'hFFFF_FFFF,
					doorbell_stride: 4'd15, queue_id: 4'd15, queue_entries: 7'(DEF_QUEUE_DEPTH),
					timeout_polls: 23'(TIMEOUT_DEFAULT)};
				default: begin
					c.enabled = ($urandom_range(0, 7) != 0);
					c.block_size_log2 = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(9, 13))
						: 4'($urandom_range(0, 15));
					c.namespace_id = $urandom;
					c.doorbell_stride = 4'($urandom_range(0, 15));
					c.queue_id = 4'($urandom_range(0, 15));
					case ($urandom_range(0, 7))
						0: c.queue_entries = 7'd0;
						1: c.queue_entries = 7'd1;
						2: c.queue_entries = 7'd2;
						3: c.queue_entries = 7'd3;
						4: c.queue_entries = 7'd64;
						5: c.queue_entries = 7'd65;
						6: c.queue_entries = 7'd127;
						default: c.queue_entries = 7'($urandom_range(2, 64));
					endcase
					case ($urandom_range(0, 4))
						0: c.timeout_polls = 23'd0;
						1: c.timeout_polls = 23'd1;
						2: c.timeout_polls = 23'($urandom_range(2, 12));
						3: c.timeout_polls = 23'(TIMEOUT_DEFAULT);
						default: c.timeout_polls = '1;
					endcase
				end
			endcase
			wait_drained();
			program_regs(c, ph >= 2 && $urandom_range(0, 3) == 0);
			for (n = 0; n < PHASE_WORDS; n++) begin
				random_item(it);
				send_word(it, 1'b0, RK_SUBMITTED);
			end
		end

		wait_drained();
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

[sim.f]
hw/rtl/nvmrq_pkg.sv
hw/rtl/nvmrq_cfg_regs.sv
hw/rtl/nvmrq_core.sv
hw/rtl/nvme_read_queue_engine.sv
sim/tb.sv
